// File: design/nearest_entry_of_type_search_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the nearest-entry search core
// Shared concurrent-assertion forms, clocked on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef NEAREST_ENTRY_OF_TYPE_SEARCH_CORE_DEFINES_SVH
`define NEAREST_ENTRY_OF_TYPE_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication.
`define NES_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nes core: same-cycle check failed");

// Next-cycle implication.
`define NES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nes core: next-cycle check failed");

`endif

// File: design/nes_pkg.sv
// ---------------------------------------------------------------------------
// nes_pkg
// Sizes, codes and state type of the nearest-entry search core.
// ---------------------------------------------------------------------------
package nes_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int TYPE_W      = 8;
  localparam int POS_W       = 16;
  localparam int DIFF_W      = POS_W + 1;
  localparam int SQ_W        = 2 * POS_W;
  localparam int DIST_W      = 34;
  localparam int OUT_IDX_W   = 6;
  localparam int ENTRY_W     = TYPE_W + 2 * POS_W;

  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 40;

  localparam logic [DIST_W-1:0] REACH_RESET = DIST_W'(64'h2_0000_0000);

  typedef enum logic {
    KIND_APPEND = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

// File: design/nearest_entry_of_type_search_core.sv
// ---------------------------------------------------------------------------
// nearest_entry_of_type_search_core
// Entry table with append and nearest-of-type query over a shared distance
// unit that is stepped across the table one entry per cycle.
// ---------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                       | tuser
//  --------+-----+------------------------------------------+------------
//  in_     | in  | item_type[7:0] pos_x[23:8] pos_y[39:24]  | kind[0]
//  out_    | out | nearest_index[5:0] nearest_dist_sq[39:6] | status[1:0]
//  cfg_    | in  | cfg_wdata = reach_sq (34 bits), cfg_we   | -
//
//  Append: the entry is stored when the beat is taken; S_DONE then loads
//    the result into the output register once it is free. Query: the table
//    memory read port feeds the distance unit (diff, square, sum, compare),
//    one entry per cycle, and S_DRAIN waits for that five-stage path to empty;
//    the drain ends early when the last entries are not of the queried type.
//  in_tready is high only in the idle state; a finished result may still
//    sit in the output register, a new beat is taken meanwhile.
//  A stalled output holds its beat; the next result waits in S_DONE.
//  Synchronous active-low reset clears the entry count, the FSM and the
//    output valid; table contents stay undefined until appended.
//
module nearest_entry_of_type_search_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [nes_pkg::IN_DATA_W-1:0] in_tdata,   // item_type, pos_x, pos_y
  input  logic                          in_tuser,   // kind
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [nes_pkg::OUT_DATA_W-1:0] out_tdata, // nearest_index, nearest_dist_sq
  output logic [1:0]                    out_tuser,  // status
  // configuration
  input  logic                          cfg_we,
  input  logic [nes_pkg::DIST_W-1:0]    cfg_wdata
);
  import nes_pkg::*;
  `include "nearest_entry_of_type_search_core_defines.svh"

  // -------------------------------------------------------------------------
  // input beat fields
  // -------------------------------------------------------------------------
  logic [TYPE_W-1:0] in_type;
  logic [POS_W-1:0]  in_x;
  logic [POS_W-1:0]  in_y;
  kind_t             in_kind;

  assign in_type = in_tdata[TYPE_W-1:0];
  assign in_x    = in_tdata[TYPE_W +: POS_W];
  assign in_y    = in_tdata[TYPE_W+POS_W +: POS_W];
  assign in_kind = kind_t'(in_tuser);

  // -------------------------------------------------------------------------
  // state
  // -------------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  scan_idx_r;
  logic [DIST_W-1:0] reach_r;

  logic [TYPE_W-1:0] q_type_r;
  logic [POS_W-1:0]  q_x_r;
  logic [POS_W-1:0]  q_y_r;

  // working result: best match during a scan, or the append outcome
  status_t           res_stat_r;
  logic [IDX_W-1:0]  res_idx_r;
  logic [DIST_W-1:0] res_dist_r;

  // output register
  logic                  out_valid_r;
  status_t               out_stat_r;
  logic [OUT_IDX_W-1:0]  out_idx_r;
  logic [DIST_W-1:0]     out_dist_r;

  logic in_fire, out_fire, table_full, issue, load_out, pipe_busy;

  // entry table, {y, x, type}
  logic [ENTRY_W-1:0] entry_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  // distance unit pipeline
  logic                     v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0]         i1_r, i2_r, i3_r, i4_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt, dx_r, dy_r;
  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
  logic [SQ_W-1:0]          sqx_r, sqy_r;
  logic [DIST_W-1:0]        d_r;
  logic                     match_nxt, take;

  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_valid_r && out_tready;
  assign table_full = (count_r >= CNT_W'(TABLE_DEPTH));
  assign pipe_busy  = v1_r || v2_r || v3_r || v4_r;

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    issue     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = (in_kind == KIND_QUERY) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_idx_r != count_r) begin
          issue = 1'b1;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      reach_r     <= REACH_RESET;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) reach_r <= cfg_wdata;
      if (in_fire && in_kind == KIND_APPEND && !table_full) count_r <= count_r + 1'b1;
      if (load_out)      out_valid_r <= 1'b1;
      else if (out_fire) out_valid_r <= 1'b0;
      v1_r <= issue;
      v2_r <= v1_r && match_nxt;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // -------------------------------------------------------------------------
  // item capture and working result
  // -------------------------------------------------------------------------
  assign take = v4_r && (d_r < reach_r) && (res_stat_r != STAT_OK || d_r < res_dist_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_type_r   <= in_type;
      q_x_r      <= in_x;
      q_y_r      <= in_y;
      scan_idx_r <= '0;
      res_idx_r  <= '0;
      res_dist_r <= '0;
      if (in_kind == KIND_QUERY) begin
        res_stat_r <= STAT_MISS;
      end else if (table_full) begin
        res_stat_r <= STAT_FULL;
      end else begin
        res_stat_r <= STAT_OK;
        res_idx_r  <= count_r[IDX_W-1:0];
      end
    end else begin
      if (issue) scan_idx_r <= scan_idx_r + 1'b1;
      if (take) begin
        res_stat_r <= STAT_OK;
        res_idx_r  <= i4_r;
        res_dist_r <= d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_stat_r <= res_stat_r;
      out_idx_r  <= OUT_IDX_W'(res_idx_r);
      out_dist_r <= res_dist_r;
    end
  end

  // -------------------------------------------------------------------------
  // entry table: one write port (append), one registered read port (scan)
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire && in_kind == KIND_APPEND && !table_full) begin
      entry_mem[count_r[IDX_W-1:0]] <= {in_y, in_x, in_type};
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= entry_mem[scan_idx_r[IDX_W-1:0]];
      i1_r      <= scan_idx_r[IDX_W-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // distance unit: diff -> square -> sum -> compare
  // -------------------------------------------------------------------------
  always_comb begin
    logic [POS_W-1:0] ex, ey;
    ex        = rd_data_r[TYPE_W +: POS_W];
    ey        = rd_data_r[TYPE_W+POS_W +: POS_W];
    match_nxt = (rd_data_r[TYPE_W-1:0] == q_type_r);
    dx_nxt    = $signed({ex[POS_W-1], ex}) - $signed({q_x_r[POS_W-1], q_x_r});
    dy_nxt    = $signed({ey[POS_W-1], ey}) - $signed({q_y_r[POS_W-1], q_y_r});
  end

  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;

  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    i2_r  <= i1_r;
    sqx_r <= sqx_full[SQ_W-1:0];   // square is below 2^32
    sqy_r <= sqy_full[SQ_W-1:0];
    i3_r  <= i2_r;
    d_r   <= DIST_W'(sqx_r) + DIST_W'(sqy_r);
    i4_r  <= i3_r;
  end

  // -------------------------------------------------------------------------
  // outputs
  // -------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_dist_r, out_idx_r});
  assign out_tuser  = out_stat_r;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  `NES_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(TABLE_DEPTH))
  `NES_ASSERT_SAME(a_idle_pipe_empty, state_r == S_IDLE, !pipe_busy)
  `NES_ASSERT_SAME(a_best_in_reach,
                   (state_r == S_SCAN || state_r == S_DRAIN) && res_stat_r == STAT_OK,
                   res_dist_r < reach_r)
  `NES_ASSERT_NEXT(a_append_count,
                   in_fire && in_kind == KIND_APPEND && !table_full,
                   count_r == $past(count_r) + 1'b1)

endmodule

// File: tb/sv/nes_checker.sv
// ---------------------------------------------------------------------------
// nes_checker
// Watches the input, result and register ports of the search core. It keeps
// its own copy of the entry table and the reach register, works out the
// answer for every accepted input beat, and compares each result beat,
// field by field, with the oldest answer still outstanding.
// ---------------------------------------------------------------------------
module nes_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [nes_pkg::IN_DATA_W-1:0]  in_tdata,   // item_type, pos_x, pos_y
  input  logic                           in_tuser,   // kind
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [nes_pkg::OUT_DATA_W-1:0] out_tdata,  // nearest_index, nearest_dist_sq
  input  logic [1:0]                     out_tuser,  // status
  input  logic                           cfg_we,
  input  logic [nes_pkg::DIST_W-1:0]     cfg_wdata,
  output int                             mismatches,
  output int                             awaited
);
  import nes_pkg::*;

  typedef struct packed {
    status_t                status;
    logic [OUT_IDX_W-1:0]   index;
    logic [DIST_W-1:0]      dist_sq;
  } answer_t;

  answer_t                   answer_q[$];
  logic [TYPE_W-1:0]         slot_type [TABLE_DEPTH];
  logic signed [POS_W-1:0]   slot_x    [TABLE_DEPTH];
  logic signed [POS_W-1:0]   slot_y    [TABLE_DEPTH];
  int unsigned               slots_used;
  logic [DIST_W-1:0]         reach;
  int                        bad_beats = 0;
  int                        open_answers = 0;

  assign mismatches = bad_beats;
  assign awaited    = open_answers;

  // Updates the table on an append; scans it on a query.
  function automatic answer_t nearest_lookup(kind_t kind, logic [TYPE_W-1:0] ty,
                                             logic signed [POS_W-1:0] px,
                                             logic signed [POS_W-1:0] py);
    answer_t           a;
    longint            dx;
    longint            dy;
    logic [DIST_W-1:0] d;
    bit                hit;
    a   = '{status: STAT_MISS, index: '0, dist_sq: '0};
    hit = 1'b0;
    if (kind == KIND_APPEND) begin
      if (slots_used >= TABLE_DEPTH) begin
        a.status = STAT_FULL;
      end else begin
        slot_type[slots_used] = ty;
        slot_x[slots_used]    = px;
        slot_y[slots_used]    = py;
        a.status = STAT_OK;
        a.index  = OUT_IDX_W'(slots_used);
        slots_used++;
      end
      return a;
    end
    for (int i = 0; i < slots_used; i++) begin
      if (slot_type[i] != ty) continue;
      dx = longint'(slot_x[i]) - longint'(px);
      dy = longint'(slot_y[i]) - longint'(py);
      d  = DIST_W'(dx * dx + dy * dy);
      if (d >= reach) continue;
      // strict compare keeps the lowest index on a tie
      if (!hit || d < a.dist_sq) begin
        hit       = 1'b1;
        a.status  = STAT_OK;
        a.index   = OUT_IDX_W'(i);
        a.dist_sq = d;
      end
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      answer_q.delete();
      slots_used = 0;
      reach      = REACH_RESET;
    end else begin
      if (cfg_we) reach = cfg_wdata;
      if (in_tvalid && in_tready)
        answer_q.insert(answer_q.size(),
                        nearest_lookup(kind_t'(in_tuser), in_tdata[7:0],
                                       in_tdata[23:8], in_tdata[39:24]));
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("%0t: unexpected result beat status=%0d index=%0d dist_sq=%0d",
                     $realtime, out_tuser, out_tdata[5:0], out_tdata[39:6]);
        end else begin
          want = answer_q.pop_front();
          if (out_tuser != want.status || out_tdata[5:0] != want.index ||
              out_tdata[39:6] != want.dist_sq) begin
            bad_beats++;
            if (bad_beats <= 10)
              $display("%0t: mismatch exp st %0d idx %0d d %0d, got st %0d idx %0d d %0d",
                       $realtime, want.status, want.index, want.dist_sq,
                       out_tuser, out_tdata[5:0], out_tdata[39:6]);
          end
        end
      end
    end
    open_answers = answer_q.size();
  end

endmodule

// File: tb/sv/nearest_entry_of_type_search_core_tb.sv
// ---------------------------------------------------------------------------
// nearest_entry_of_type_search_core_tb
// Drives appends, queries and reach settings into the search core, with
// random gaps on both channels. Prediction and comparison live in
// nes_checker; this top makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module nearest_entry_of_type_search_core_tb;
  import nes_pkg::*;

  localparam int BEATS_PER_PHASE = 80;
  localparam int PHASES          = 6;
  localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES    = 80;    // idle time before the verdict

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // item_type[7:0], pos_x[23:8], pos_y[39:24]
  logic                  in_tuser;   // kind
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // nearest_index[5:0], nearest_dist_sq[39:6]
  logic [1:0]            out_tuser;  // status
  logic                  cfg_we;
  logic [DIST_W-1:0]     cfg_wdata;

  int mismatches;
  int awaited;
  int beats_sent     = 0;
  int appends_sent   = 0;
  int results_seen   = 0;
  bit long_hold_done = 1'b0;

  nearest_entry_of_type_search_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  nes_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #(12 * 1000000);
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) results_seen++;

  // Receiver. Random stalls, one long hold-off so the core backs up into
  // in_tready, and a quiet window where it always takes the beat.
  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= 150) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_done = 1'b1;
      end
      out_tready = (results_seen >= 300 && results_seen < 380) ||
                   ($urandom_range(99) >= 28);
    end
  end

  // One input beat. Called right after an accepting edge (or from idle);
  // returns at the edge where the beat is taken.
  task automatic send_beat(input kind_t kind, input logic [TYPE_W-1:0] ty,
                           input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
    bit gaps_on;
    gaps_on = !(beats_sent >= 300 && beats_sent < 380);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 28) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {py, px, ty};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    if (kind == KIND_APPEND) appends_sent++;
  endtask

  // Sender pause: nothing offered until every answer has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (awaited != 0) @(negedge clk);
  endtask

  // Only called with the core idle.
  task automatic write_reach(input logic [DIST_W-1:0] value);
    @(negedge clk);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    logic [TYPE_W-1:0] type_pool [3];
    logic [POS_W-1:0]  spot_x [4];
    logic [POS_W-1:0]  spot_y [4];
    logic [TYPE_W-1:0] ty;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [DIST_W-1:0] reach;
    kind_t             kind;
    int                c;

    type_pool = '{8'h11, 8'h5A, 8'hC3};
    // cluster centers, two of them near the wrap points
    spot_x    = '{16'h0000, 16'h7FC0, 16'h8020, 16'h1234};
    spot_y    = '{16'h0000, 16'h8010, 16'h7FE0, 16'hEDCC};

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = KIND_APPEND;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // ---- directed part, reach at its reset value (2^33) ----
    send_beat(KIND_QUERY,  8'h00, 16'h0000, 16'h0000);  // empty table: miss
    send_beat(KIND_APPEND, 8'h00, 16'h8000, 16'h8000);  // slot 0, most negative
    send_beat(KIND_APPEND, 8'hFF, 16'h7FFF, 16'h7FFF);  // slot 1, most positive
    send_beat(KIND_QUERY,  8'h00, 16'h7FFF, 16'h7FFF);  // largest distance, still in reach
    send_beat(KIND_QUERY,  8'hFF, 16'h8000, 16'h8000);
    send_beat(KIND_QUERY,  8'h07, 16'h0000, 16'h0000);  // no entry of this type
    send_beat(KIND_APPEND, 8'h07, 16'h0010, 16'h0010);  // slot 2
    send_beat(KIND_APPEND, 8'h07, 16'hFFF0, 16'hFFF0);  // slot 3, mirror of slot 2
    send_beat(KIND_QUERY,  8'h07, 16'h0000, 16'h0000);  // tie: slot 2 wins, d = 512
    send_beat(KIND_QUERY,  8'h07, 16'h0010, 16'h0010);  // exact hit, d = 0
    send_beat(KIND_APPEND, 8'h5A, 16'hFFFF, 16'h0000);  // slot 4
    send_beat(KIND_QUERY,  8'h5A, 16'h0000, 16'hFFFF);

    // reach edge: a distance equal to reach does not count
    wait_drained();
    write_reach(DIST_W'(512));
    send_beat(KIND_QUERY,  8'h07, 16'h0000, 16'h0000);  // miss
    wait_drained();
    write_reach(DIST_W'(513));
    send_beat(KIND_QUERY,  8'h07, 16'h0000, 16'h0000);  // slot 2
    wait_drained();
    write_reach('0);
    send_beat(KIND_QUERY,  8'h07, 16'h0010, 16'h0010);  // even d = 0 is out of reach

    // ---- random phases, a new reach before each ----
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       reach = REACH_RESET;
        1:       reach = DIST_W'(20000);
        2: begin
          reach = DIST_W'({$urandom_range(1), $urandom});
          if (reach > REACH_RESET) reach = REACH_RESET;
        end
        3:       reach = '0;
        4:       reach = DIST_W'(1 << 24);
        default: reach = REACH_RESET;
      endcase
      write_reach(reach);

      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        // appends lean heavier until the table is full, then keep hitting full
        kind = ($urandom_range(99) < (appends_sent < TABLE_DEPTH ? 40 : 15)) ?
               KIND_APPEND : KIND_QUERY;
        ty   = ($urandom_range(99) < 80) ? type_pool[$urandom_range(2)]
                                         : TYPE_W'($urandom_range(255));
        if ($urandom_range(1)) begin
          px = POS_W'($urandom);
          py = POS_W'($urandom);
        end else begin
          // offsets on a 16-unit grid make equal distances common
          c  = $urandom_range(3);
          px = spot_x[c] + POS_W'($urandom_range(8) * 16) - POS_W'(64);
          py = spot_y[c] + POS_W'($urandom_range(8) * 16) - POS_W'(64);
        end
        send_beat(kind, ty, px, py);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && awaited == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
